// ===== rtl/core/mgpem_pkg.sv =====
// Package for the marker-gated power and energy meter.
// Holds widths, the constant reciprocal for millivolt scaling, register indexes,
// and the command and status types between the controller and the datapath.
package mgpem_pkg;

    localparam int unsigned ADC_FULL_SCALE = 32767;

    localparam int unsigned MV_W     = 16;
    localparam int unsigned RANGE_W  = 15;
    localparam int unsigned SCALE_W  = 32;
    localparam int unsigned PERIOD_W = 32;
    localparam int unsigned PWR_W    = 48;
    localparam int unsigned ENERGY_W = 64;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned MUL_W    = 32;
    localparam int unsigned PROD_W   = 2 * MUL_W;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ADDR_W   = 5;

    // Exact division of a 30-bit magnitude by the full-scale constant via a
    // rounded-up reciprocal and a right shift.
    localparam int unsigned DIV_IN_W  = 30;
    localparam int unsigned DIV_LOG   = $clog2(ADC_FULL_SCALE);
    localparam int unsigned DIV_SHIFT = DIV_IN_W + DIV_LOG;
    localparam logic [PROD_W-1:0] DIV_RECIP =
        ((64'd1 << DIV_SHIFT) + 64'(ADC_FULL_SCALE) - 64'd1) / 64'(ADC_FULL_SCALE);

    typedef enum logic [2:0] {
        REG_THRESHOLD     = 3'd0,
        REG_MARKER_RANGE  = 3'd1,
        REG_CHANNEL_RANGE = 3'd2,
        REG_SCALE_EN      = 3'd3,
        REG_POWER_SCALE   = 3'd4,
        REG_SAMPLE_PERIOD = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [MV_W-1:0]     marker_threshold_mv;
        logic [RANGE_W-1:0]  marker_range_mv;
        logic [RANGE_W-1:0]  channel_range_mv;
        logic                scale_enable;
        logic [SCALE_W-1:0]  power_scale;
        logic [PERIOD_W-1:0] sample_period;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_MARKER      = 3'd0,
        MUL_MARKER_DIV  = 3'd1,
        MUL_CHANNEL     = 3'd2,
        MUL_CHANNEL_DIV = 3'd3,
        MUL_POWER       = 3'd4,
        MUL_ENERGY_LOW  = 3'd5,
        MUL_ENERGY_HIGH = 3'd6
    } mul_sel_t;

    typedef struct packed {
        logic     load_sample;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     cap_marker;
        logic     cap_power;
        logic     cap_energy_low;
        logic     cap_step;
        logic     update;
        logic     close;
    } dp_cmd_t;

    typedef struct packed {
        logic marked;
        logic in_window;
        logic record_free;
    } dp_status_t;

endpackage

// ===== rtl/core/mgpem_in_if.sv =====
// Input channel of the meter: one marker sample and one measured sample per transfer.
// Depends on mgpem_pkg for the field widths.
interface mgpem_in_if;
    import mgpem_pkg::*;

    logic            valid;
    logic            ready;
    logic [MV_W-1:0] marker_raw;
    logic [MV_W-1:0] sample_raw;

    modport source (output valid, output marker_raw, output sample_raw, input ready);
    modport sink (input valid, input marker_raw, input sample_raw, output ready);

endinterface

// ===== rtl/core/mgpem_out_if.sv =====
// Output channel of the meter: one window record per transfer.
// Depends on mgpem_pkg for the field widths.
interface mgpem_out_if;
    import mgpem_pkg::*;

    logic                valid;
    logic                ready;
    logic [ENERGY_W-1:0] energy;
    logic [TIME_W-1:0]   elapsed_time;
    logic [COUNT_W-1:0]  sample_total;
    logic [PWR_W-1:0]    max_power;
    logic [PWR_W-1:0]    min_power;

    modport source (
        output valid, output energy, output elapsed_time, output sample_total,
        output max_power, output min_power, input ready
    );
    modport sink (
        input valid, input energy, input elapsed_time, input sample_total,
        input max_power, input min_power, output ready
    );

endinterface

// ===== rtl/core/marker_gated_power_energy_meter_unit.sv =====
// Top level of the marker-gated power and energy meter.
// A sample above the marker level goes on through power and energy before the next ready; one
// below closes an open window once the record slot is free, the record valid the cycle after.
// Seven products per marked sample run one after another through one shared 32x32 multiplier.
// The record register holds a finished record while further samples are taken.
// Reset (asynchronous, active low) empties the sequencer, the window and the record register.
module marker_gated_power_energy_meter_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    mgpem_in_if.sink                     sample_ch,
    mgpem_out_if.source                  record_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mgpem_pkg::ADDR_W-1:0] paddr,
    input  logic [mgpem_pkg::DATA_W-1:0] pwdata,
    output logic [mgpem_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);
    import mgpem_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    mgpem_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mgpem_controller u_controller (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_ch.valid),
        .sample_ready (sample_ch.ready),
        .cmd          (cmd),
        .status       (status)
    );

    mgpem_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg),
        .marker_raw   (sample_ch.marker_raw),
        .sample_raw   (sample_ch.sample_raw),
        .record_valid (record_ch.valid),
        .record_ready (record_ch.ready),
        .energy       (record_ch.energy),
        .elapsed_time (record_ch.elapsed_time),
        .sample_total (record_ch.sample_total),
        .max_power    (record_ch.max_power),
        .min_power    (record_ch.min_power)
    );

endmodule

// ===== rtl/core/mgpem_regs.sv =====
// APB-style configuration register file of the meter.
// Depends on mgpem_pkg for the register indexes and the configuration struct.
module mgpem_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mgpem_pkg::ADDR_W-1:0] paddr,
    input  logic [mgpem_pkg::DATA_W-1:0] pwdata,
    output logic [mgpem_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output mgpem_pkg::cfg_t              cfg
);
    import mgpem_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       write_en;

    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite;
    assign index    = reg_index_t'(paddr[ADDR_W-1:2]);
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            case (index)
                REG_THRESHOLD:     cfg_next.marker_threshold_mv = pwdata[MV_W-1:0];
                REG_MARKER_RANGE:  cfg_next.marker_range_mv = pwdata[RANGE_W-1:0];
                REG_CHANNEL_RANGE: cfg_next.channel_range_mv = pwdata[RANGE_W-1:0];
                REG_SCALE_EN:      cfg_next.scale_enable = pwdata[0];
                REG_POWER_SCALE:   cfg_next.power_scale = pwdata[SCALE_W-1:0];
                REG_SAMPLE_PERIOD: cfg_next.sample_period = pwdata[PERIOD_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_THRESHOLD:
                prdata = {{(DATA_W-MV_W){cfg_reg.marker_threshold_mv[MV_W-1]}},
                          cfg_reg.marker_threshold_mv};
            REG_MARKER_RANGE:  prdata = DATA_W'(cfg_reg.marker_range_mv);
            REG_CHANNEL_RANGE: prdata = DATA_W'(cfg_reg.channel_range_mv);
            REG_SCALE_EN:      prdata = DATA_W'(cfg_reg.scale_enable);
            REG_POWER_SCALE:   prdata = DATA_W'(cfg_reg.power_scale);
            REG_SAMPLE_PERIOD: prdata = DATA_W'(cfg_reg.sample_period);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.marker_threshold_mv <= MV_W'(1000);
            cfg_reg.marker_range_mv     <= RANGE_W'(5000);
            cfg_reg.channel_range_mv    <= RANGE_W'(1000);
            cfg_reg.scale_enable        <= 1'b1;
            cfg_reg.power_scale         <= '0;
            cfg_reg.sample_period       <= PERIOD_W'(4294967);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/mgpem_datapath.sv =====
// Datapath of the meter: one shared 32x32 multiplier, the window sums and the record register.
// Depends on mgpem_pkg; steered step by step by mgpem_controller.
module mgpem_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mgpem_pkg::dp_cmd_t             cmd,
    output mgpem_pkg::dp_status_t          status,
    input  mgpem_pkg::cfg_t                cfg,
    input  logic [mgpem_pkg::MV_W-1:0]     marker_raw,
    input  logic [mgpem_pkg::MV_W-1:0]     sample_raw,
    output logic                           record_valid,
    input  logic                           record_ready,
    output logic [mgpem_pkg::ENERGY_W-1:0] energy,
    output logic [mgpem_pkg::TIME_W-1:0]   elapsed_time,
    output logic [mgpem_pkg::COUNT_W-1:0]  sample_total,
    output logic [mgpem_pkg::PWR_W-1:0]    max_power,
    output logic [mgpem_pkg::PWR_W-1:0]    min_power
);
    import mgpem_pkg::*;

    logic [MV_W-1:0]     marker_raw_reg;
    logic [MV_W-1:0]     sample_raw_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                marked_reg;
    logic [PWR_W-1:0]    power_reg;
    logic [PWR_W-1:0]    pmag_reg;
    logic [MUL_W-1:0]    elow_reg;
    logic [PWR_W-1:0]    step_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic [ENERGY_W-1:0] energy_next;
    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   time_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [PWR_W-1:0]    high_reg;
    logic [PWR_W-1:0]    high_next;
    logic [PWR_W-1:0]    low_reg;
    logic [PWR_W-1:0]    low_next;
    logic                in_window_reg;
    logic                record_valid_reg;
    logic [ENERGY_W-1:0] rec_energy_reg;
    logic [TIME_W-1:0]   rec_time_reg;
    logic [COUNT_W-1:0]  rec_count_reg;
    logic [PWR_W-1:0]    rec_high_reg;
    logic [PWR_W-1:0]    rec_low_reg;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [PROD_W-1:0]   mul_prod;
    logic [MV_W-1:0]     marker_mag;
    logic [MV_W-1:0]     sample_mag;
    logic [MV_W-1:0]     quotient;
    logic [MV_W-1:0]     marker_mv;
    logic [MV_W-1:0]     channel_mag;
    logic [PWR_W-1:0]    power_mag;
    logic [PWR_W-1:0]    energy_q;
    logic [ENERGY_W-1:0] energy_base;
    logic [ENERGY_W:0]   energy_sum;
    logic [TIME_W:0]     time_sum;
    logic                record_free;

    assign marker_mag  = marker_raw_reg[MV_W-1] ? (~marker_raw_reg + 1'b1) : marker_raw_reg;
    assign sample_mag  = sample_raw_reg[MV_W-1] ? (~sample_raw_reg + 1'b1) : sample_raw_reg;
    assign quotient    = prod_reg[DIV_SHIFT+MV_W-1:DIV_SHIFT];
    assign marker_mv   = !cfg.scale_enable ? marker_raw_reg
                       : (marker_raw_reg[MV_W-1] ? (~quotient + 1'b1) : quotient);
    assign channel_mag = cfg.scale_enable ? quotient : sample_mag;
    assign power_mag   = prod_reg[PWR_W-1:0];
    assign energy_q    = prod_reg[PWR_W-1:0] + PWR_W'(elow_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_MARKER:
            begin
                mul_a = MUL_W'(marker_mag);
                mul_b = MUL_W'(cfg.marker_range_mv);
            end
            MUL_MARKER_DIV, MUL_CHANNEL_DIV:
            begin
                mul_a = MUL_W'(prod_reg[DIV_IN_W-1:0]);
                mul_b = DIV_RECIP[MUL_W-1:0];
            end
            MUL_CHANNEL:
            begin
                mul_a = MUL_W'(sample_mag);
                mul_b = MUL_W'(cfg.channel_range_mv);
            end
            MUL_POWER:
            begin
                mul_a = MUL_W'(channel_mag);
                mul_b = cfg.power_scale;
            end
            MUL_ENERGY_LOW:
            begin
                mul_a = pmag_reg[MUL_W-1:0];
                mul_b = cfg.sample_period;
            end
            MUL_ENERGY_HIGH:
            begin
                mul_a = MUL_W'(pmag_reg[PWR_W-1:MUL_W]);
                mul_b = cfg.sample_period;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // The first sample of a window starts from empty sums.
    assign energy_base = in_window_reg ? energy_reg : '0;
    assign energy_sum  = {energy_base[ENERGY_W-1], energy_base}
                       + {{(ENERGY_W+1-PWR_W){step_reg[PWR_W-1]}}, step_reg};
    assign time_sum    = (in_window_reg ? {1'b0, time_reg} : '0)
                       + (TIME_W+1)'(cfg.sample_period);

    always_comb
    begin
        if (energy_sum[ENERGY_W] != energy_sum[ENERGY_W-1])
        begin
            energy_next = energy_sum[ENERGY_W] ? {1'b1, {(ENERGY_W-1){1'b0}}}
                                               : {1'b0, {(ENERGY_W-1){1'b1}}};
        end
        else
        begin
            energy_next = energy_sum[ENERGY_W-1:0];
        end

        time_next = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];

        if (!in_window_reg)
        begin
            count_next = COUNT_W'(1);
            high_next  = power_reg;
            low_next   = power_reg;
        end
        else
        begin
            count_next = (&count_reg) ? count_reg : count_reg + 1'b1;
            high_next  = ($signed(power_reg) > $signed(high_reg)) ? power_reg : high_reg;
            low_next   = ($signed(power_reg) < $signed(low_reg)) ? power_reg : low_reg;
        end
    end

    assign record_free = !record_valid_reg || record_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            marker_raw_reg <= marker_raw;
            sample_raw_reg <= sample_raw;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_prod;
        end
        if (cmd.cap_marker)
        begin
            marked_reg <= $signed(marker_mv) > $signed(cfg.marker_threshold_mv);
        end
        // The product magnitude stays below 2^47, so it never reaches the 48-bit limits.
        if (cmd.cap_power)
        begin
            pmag_reg  <= power_mag;
            power_reg <= sample_raw_reg[MV_W-1] ? (~power_mag + 1'b1) : power_mag;
        end
        if (cmd.cap_energy_low)
        begin
            elow_reg <= prod_reg[PROD_W-1:MUL_W];
        end
        if (cmd.cap_step)
        begin
            step_reg <= sample_raw_reg[MV_W-1] ? (~energy_q + 1'b1) : energy_q;
        end
        if (cmd.update)
        begin
            energy_reg <= energy_next;
            time_reg   <= time_next;
            count_reg  <= count_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
        end
        if (cmd.close)
        begin
            rec_energy_reg <= energy_reg;
            rec_time_reg   <= time_reg;
            rec_count_reg  <= count_reg;
            rec_high_reg   <= high_reg;
            rec_low_reg    <= low_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_window_reg    <= 1'b0;
            record_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                in_window_reg <= 1'b1;
            end
            else if (cmd.close)
            begin
                in_window_reg <= 1'b0;
            end

            if (cmd.close)
            begin
                record_valid_reg <= 1'b1;
            end
            else if (record_ready)
            begin
                record_valid_reg <= 1'b0;
            end
        end
    end

    assign status.marked      = marked_reg;
    assign status.in_window   = in_window_reg;
    assign status.record_free = record_free;

    assign record_valid = record_valid_reg;
    assign energy       = rec_energy_reg;
    assign elapsed_time = rec_time_reg;
    assign sample_total = rec_count_reg;
    assign max_power    = rec_high_reg;
    assign min_power    = rec_low_reg;

endmodule

// ===== rtl/core/mgpem_controller.sv =====
// Sequencing state machine of the meter: steps each accepted sample through the datapath.
// Depends on mgpem_pkg for the command and status structs.
module mgpem_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    output mgpem_pkg::dp_cmd_t    cmd,
    input  mgpem_pkg::dp_status_t status
);
    import mgpem_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_M_PROD = 12'b0000_0000_0010,
        ST_M_DIV  = 12'b0000_0000_0100,
        ST_C_PROD = 12'b0000_0000_1000,
        ST_C_DIV  = 12'b0000_0001_0000,
        ST_POWER  = 12'b0000_0010_0000,
        ST_PSAT   = 12'b0000_0100_0000,
        ST_E_LOW  = 12'b0000_1000_0000,
        ST_E_HIGH = 12'b0001_0000_0000,
        ST_ESTEP  = 12'b0010_0000_0000,
        ST_UPDATE = 12'b0100_0000_0000,
        ST_CLOSE  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign sample_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_MARKER;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_M_PROD;
                end
            end
            ST_M_PROD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MARKER;
                state_next  = ST_M_DIV;
            end
            ST_M_DIV:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MARKER_DIV;
                state_next  = ST_C_PROD;
            end
            ST_C_PROD:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_CHANNEL;
                cmd.cap_marker = 1'b1;
                state_next     = ST_C_DIV;
            end
            ST_C_DIV:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CHANNEL_DIV;
                if (status.marked)
                begin
                    state_next = ST_POWER;
                end
                else if (status.in_window)
                begin
                    state_next = ST_CLOSE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POWER:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_POWER;
                state_next  = ST_PSAT;
            end
            ST_PSAT:
            begin
                cmd.cap_power = 1'b1;
                state_next    = ST_E_LOW;
            end
            ST_E_LOW:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ENERGY_LOW;
                state_next  = ST_E_HIGH;
            end
            ST_E_HIGH:
            begin
                cmd.mul_en         = 1'b1;
                cmd.mul_sel        = MUL_ENERGY_HIGH;
                cmd.cap_energy_low = 1'b1;
                state_next         = ST_ESTEP;
            end
            ST_ESTEP:
            begin
                cmd.cap_step = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CLOSE:
            begin
                if (status.record_free)
                begin
                    cmd.close  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/mgpem_checker.sv =====
// Port-level assertions for the meter, bound to the top level.
// Depends on mgpem_pkg for widths and register indexes.
module mgpem_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           sample_valid,
    input logic                           sample_ready,
    input logic                           record_valid,
    input logic                           record_ready,
    input logic [mgpem_pkg::ENERGY_W-1:0] energy,
    input logic [mgpem_pkg::COUNT_W-1:0]  sample_total,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [mgpem_pkg::ADDR_W-1:0]   paddr,
    input logic [mgpem_pkg::DATA_W-1:0]   pwdata,
    input logic [mgpem_pkg::DATA_W-1:0]   prdata,
    input logic                           pready
);
    import mgpem_pkg::*;

    // The marker must be converted before the next sample can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready)
        |=> !sample_ready ##1 !sample_ready ##1 !sample_ready ##1 !sample_ready)
    else $error("sample taken while the previous one is still in conversion");

    assert property (@(posedge clk) disable iff (!rst_n)
        (record_valid && !record_ready)
        |=> record_valid && $stable(energy) && $stable(sample_total))
    else $error("stalled record dropped or changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(record_valid) |-> $past(record_ready))
    else $error("record withdrawn without a transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_SCALE_EN)
        ##1 (psel && !pwrite && paddr[ADDR_W-1:2] == REG_SCALE_EN)
        |-> prdata == DATA_W'($past(pwdata[0])))
    else $error("scale enable readback differs from the written value");

endmodule

bind marker_gated_power_energy_meter_unit mgpem_checker u_mgpem_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_ch.valid),
    .sample_ready (sample_ch.ready),
    .record_valid (record_ch.valid),
    .record_ready (record_ch.ready),
    .energy       (record_ch.energy),
    .sample_total (record_ch.sample_total),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
);

// ===== tb/mgpem_record_checker.sv =====
// Checker for the marker-gated power and energy meter: follows register writes and sample
// transfers, predicts each window record and compares it with the record transfers.
// Depends on mgpem_pkg and on the mgpem_in_if and mgpem_out_if interfaces.
module mgpem_record_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    mgpem_in_if                          sample_ch,
    mgpem_out_if                         record_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mgpem_pkg::ADDR_W-1:0] paddr,
    input  logic [mgpem_pkg::DATA_W-1:0] pwdata,
    input  logic                         pready,
    output int unsigned                  failures,
    output int unsigned                  records_pending
);
    import mgpem_pkg::*;

    localparam longint POWER_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint POWER_MIN  = -64'sh0000_8000_0000_0000;
    localparam longint ENERGY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ENERGY_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [TIME_W-1:0]   elapsed_time;
        logic [COUNT_W-1:0]  sample_total;
        logic [PWR_W-1:0]    max_power;
        logic [PWR_W-1:0]    min_power;
    } window_record_t;

    window_record_t expected_records[$];

    logic signed [MV_W-1:0] threshold_mv;
    logic [RANGE_W-1:0]     marker_range;
    logic [RANGE_W-1:0]     channel_range;
    logic                   scale_en;
    logic [SCALE_W-1:0]     power_scale_q;
    logic [PERIOD_W-1:0]    period_q;

    logic               open_window;
    longint             energy_acc;
    logic [TIME_W-1:0]  time_acc;
    logic [COUNT_W-1:0] count_acc;
    longint             power_high;
    longint             power_low;

    int unsigned mismatches = 0;
    int unsigned records_seen = 0;

    function automatic longint to_millivolts(input logic signed [MV_W-1:0] raw,
                                             input logic [RANGE_W-1:0] range_mv);
        if (!scale_en)
            return longint'(raw);
        return (longint'(raw) * longint'(range_mv)) / longint'(ADC_FULL_SCALE);
    endfunction

    function automatic longint power_of(input longint mv);
        logic [63:0] amv;
        logic [63:0] mag;
        amv = (mv < 0) ? -mv : mv;
        mag = amv * {32'd0, power_scale_q};
        if (mv >= 0)
            return (mag > POWER_MAX) ? POWER_MAX : longint'(mag);
        if (mag >= (64'd1 << 47))
            return POWER_MIN;
        return -longint'(mag);
    endfunction

    function automatic longint energy_step(input longint p);
        logic [63:0] amag;
        logic [63:0] upper;
        logic [63:0] lower;
        logic [63:0] q;
        amag  = (p < 0) ? -p : p;
        upper = amag * {48'd0, period_q[31:16]};
        lower = amag * {48'd0, period_q[15:0]};
        q     = (upper + (lower >> 16)) >> 16;
        return (p < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint add_energy(input longint acc, input longint inc);
        longint total;
        total = acc + inc;
        if (inc > 0 && total < acc)
            return ENERGY_MAX;
        if (inc < 0 && total > acc)
            return ENERGY_MIN;
        return total;
    endfunction

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        $display("record %0d %s: got %h, expected %h", records_seen, field, got, want);
        mismatches++;
    endtask

    task automatic check_record();
        window_record_t want;
        records_seen++;
        if (expected_records.size() == 0)
        begin
            report("arrived with no closed window", record_ch.energy, '0);
        end
        else
        begin
            want = expected_records.pop_front();
            if (record_ch.energy !== want.energy)
                report("energy", record_ch.energy, want.energy);
            if (record_ch.elapsed_time !== want.elapsed_time)
                report("elapsed_time", record_ch.elapsed_time, want.elapsed_time);
            if (record_ch.sample_total !== want.sample_total)
                report("sample_total", record_ch.sample_total, want.sample_total);
            if (record_ch.max_power !== want.max_power)
                report("max_power", record_ch.max_power, want.max_power);
            if (record_ch.min_power !== want.min_power)
                report("min_power", record_ch.min_power, want.min_power);
        end
    endtask

    task automatic take_sample(input logic signed [MV_W-1:0] marker,
                               input logic signed [MV_W-1:0] level);
        longint         p;
        logic [TIME_W:0] time_next;
        window_record_t rec;
        if (to_millivolts(marker, marker_range) <= longint'(threshold_mv))
        begin
            if (open_window)
            begin
                open_window      = 1'b0;
                rec.energy       = energy_acc;
                rec.elapsed_time = time_acc;
                rec.sample_total = count_acc;
                rec.max_power    = power_high[PWR_W-1:0];
                rec.min_power    = power_low[PWR_W-1:0];
                expected_records = {expected_records, rec};
            end
        end
        else
        begin
            p = power_of(to_millivolts(level, channel_range));
            if (!open_window)
            begin
                open_window = 1'b1;
                energy_acc  = 0;
                time_acc    = '0;
                count_acc   = '0;
                power_high  = p;
                power_low   = p;
            end
            energy_acc = add_energy(energy_acc, energy_step(p));
            time_next  = {1'b0, time_acc} + {33'd0, period_q};
            time_acc   = time_next[TIME_W] ? '1 : time_next[TIME_W-1:0];
            if (count_acc != '1)
                count_acc = count_acc + 1'b1;
            if (p > power_high)
                power_high = p;
            if (p < power_low)
                power_low = p;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_mv  = 16'sd1000;
            marker_range  = 15'd5000;
            channel_range = 15'd1000;
            scale_en      = 1'b1;
            power_scale_q = '0;
            period_q      = 32'd4294967;
            open_window   = 1'b0;
            energy_acc    = 0;
            time_acc      = '0;
            count_acc     = '0;
            power_high    = 0;
            power_low     = 0;
            expected_records.delete();
            failures        <= mismatches;
            records_pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[ADDR_W-1:2]))
                    REG_THRESHOLD:     threshold_mv  = pwdata[MV_W-1:0];
                    REG_MARKER_RANGE:  marker_range  = pwdata[RANGE_W-1:0];
                    REG_CHANNEL_RANGE: channel_range = pwdata[RANGE_W-1:0];
                    REG_SCALE_EN:      scale_en      = pwdata[0];
                    REG_POWER_SCALE:   power_scale_q = pwdata[SCALE_W-1:0];
                    REG_SAMPLE_PERIOD: period_q      = pwdata[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (record_ch.valid && record_ch.ready)
                check_record();
            if (sample_ch.valid && sample_ch.ready)
                take_sample(sample_ch.marker_raw, sample_ch.sample_raw);
            failures        <= mismatches;
            records_pending <= expected_records.size();
        end
    end

endmodule

// ===== tb/marker_gated_power_energy_meter_unit_tb.sv =====
// Testbench top for the marker-gated power and energy meter: clock, reset, register writes,
// bursty sample transfers, a stalling record receiver, a watchdog and the verdict.
// Depends on mgpem_pkg, the channel interfaces, the meter and mgpem_record_checker.
module marker_gated_power_energy_meter_unit_tb;
    import mgpem_pkg::*;

    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned SETTLE_CYCLES   = 12;
    localparam int unsigned PHASES          = 6;
    localparam int unsigned ITEMS_PER_PHASE = 92;
    localparam logic [2:0]  SPARE_REG       = 3'd6;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_PATTERN,
        STALL_RANDOM
    } stall_mode_t;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic        rx_ready      = 1'b0;
    logic [4:0]  stall_tick    = '0;
    stall_mode_t stall_mode    = STALL_NONE;
    logic [31:0] stall_pattern = '1;
    int unsigned idle_cycles   = 0;
    int unsigned failures;
    int unsigned records_pending;
    int          burst_left    = 0;

    mgpem_in_if  sample_ch ();
    mgpem_out_if record_ch ();

    assign record_ch.ready = rx_ready;

    marker_gated_power_energy_meter_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .record_ch (record_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    mgpem_record_checker record_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_ch       (sample_ch),
        .record_ch       (record_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .failures        (failures),
        .records_pending (records_pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 5'd1;
        if (stall_tick == '0)
        begin
            stall_mode    <= stall_mode_t'($urandom_range(0, 2));
            stall_pattern <= $urandom | 32'h1;
        end
        case (stall_mode)
            STALL_NONE:    rx_ready <= 1'b1;
            STALL_PATTERN: rx_ready <= stall_pattern[stall_tick];
            default:       rx_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (record_ch.valid && record_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic scale, input logic [31:0] mrange,
                             input logic [31:0] crange, input logic [31:0] thr,
                             input logic [31:0] pscale, input logic [31:0] period);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MARKER_RANGE, mrange);
        write_reg(REG_CHANNEL_RANGE, crange);
        write_reg(REG_SCALE_EN, {31'd0, scale});
        write_reg(REG_POWER_SCALE, pscale);
        write_reg(REG_SAMPLE_PERIOD, period);
    endtask

    task automatic push_sample(input int marker_val, input int level_val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.marker_raw <= marker_val[15:0];
        sample_ch.sample_raw <= level_val[15:0];
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic drain(input logic settle);
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (records_pending != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int marked_raw(input int thr_raw, input int raw_step);
        return int'($urandom_range(thr_raw + raw_step + 32768, 65535)) - 32768;
    endfunction

    function automatic int unmarked_raw(input int thr_raw);
        return int'($urandom_range(0, thr_raw + 32768)) - 32768;
    endfunction

    function automatic int channel_raw();
        case ($urandom_range(0, 15))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            default: return int'($urandom);
        endcase
    endfunction

    task automatic run_windows(input int target, input int thr_raw, input int raw_step);
        int done;
        int len;
        int extra;
        done = 0;
        while (done < target)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                push_sample(int'($urandom), int'($urandom));
                done++;
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                repeat (len) push_sample(marked_raw(thr_raw, raw_step), channel_raw());
                extra = $urandom_range(1, 3);
                repeat (extra) push_sample(unmarked_raw(thr_raw), channel_raw());
                done += len + extra;
            end
        end
    endtask

    initial
    begin
        int   ph;
        logic scale;
        int   mrange;
        int   crange;
        int   thr_raw;
        int   thr_mv;
        int   raw_step;
        logic [31:0] pscale;
        logic [31:0] period;

        sample_ch.valid      <= 1'b0;
        sample_ch.marker_raw <= '0;
        sample_ch.sample_raw <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Raw values, unit power scale, half-second period.
        configure(1'b0, 5000, 1000, 0, 32'h0100_0000, 32'h8000_0000);
        push_sample(0, 5);
        push_sample(1, 32767);
        push_sample(32767, -32768);
        push_sample(1, 0);
        push_sample(0, 100);
        push_sample(-32768, 7);
        push_sample(32767, -1);
        push_sample(-32768, 0);
        drain(1'b1);

        // Lowest threshold with the largest power scale and period drives the largest power.
        configure(1'b0, 5000, 1000, -32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_sample(-32767, 32767);
        push_sample(32767, -32768);
        push_sample(0, -1);
        push_sample(-32768, 0);
        drain(1'b1);

        // Highest threshold: no marker can open a window.
        configure(1'b0, 5000, 1000, 32767, 32'h0100_0000, 32'h8000_0000);
        push_sample(32767, 1);
        push_sample(-32768, 1);
        drain(1'b1);

        configure(1'b1, 10, 20000, -1, 32'h0000_3000, 32'h0);
        push_sample(32767, 32767);
        push_sample(0, -32768);
        push_sample(-32768, 5);
        drain(1'b1);

        // The upper bits are dropped, leaving the channel range at zero.
        write_reg(SPARE_REG, 32'hFFFF_FFFF);
        configure(1'b1, 20000, 32'hFFFF_8000, 1000, 32'h0100_0000, 32'd4294967);
        push_sample(32767, 12345);
        push_sample(-5, 0);

        for (ph = 0; ph < PHASES; ph++)
        begin
            scale  = (ph == 1 || ph == 4) ? 1'b0 : 1'b1;
            mrange = (ph == 2) ? 10 : (ph == 3) ? 20000 : $urandom_range(10, 20000);
            crange = (ph == 2) ? 20000 : (ph == 3) ? 10 : $urandom_range(10, 20000);
            pscale = (ph == 1) ? 32'hFFFF_FFFF : (ph == 3) ? 32'h0 :
                     (ph == 5) ? $urandom : $urandom_range(0, 32'h0400_0000);
            period = (ph == 1) ? 32'hFFFF_FFFF : (ph == 3) ? 32'h0 : $urandom;
            thr_raw  = int'($urandom_range(0, 40000)) - 20000;
            thr_mv   = scale ? thr_raw * mrange / int'(ADC_FULL_SCALE) : thr_raw;
            raw_step = scale ? 2 * int'(ADC_FULL_SCALE) / mrange + 2 : 1;
            drain(1'b1);
            configure(scale, mrange, crange, thr_mv, pscale, period);
            run_windows(ITEMS_PER_PHASE / 2, thr_raw, raw_step);
            if (ph % 2 == 0)
                drain(1'b0);
            run_windows(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2, thr_raw, raw_step);
        end
        drain(1'b1);

        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
